### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is low
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sha256 check failed");

// condition that must never be seen at a clock edge
`define CHK_NEVER(label, clk, rst_n, expr) \
    `CHK_ASSERT(label, clk, rst_n, !(expr))

`endif

### hw/rtl/sha_pkg.sv
// types, constants and round constant table for the sha-256 engine
// no dependencies
package sha_pkg;

    localparam logic [31:0] SHA_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] PAD_MARK   = 32'h8000_0000;
    localparam logic [5:0]  LAST_ROUND = 6'd63;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FFWD
    } t_core_state;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_BLOCK,
        SEQ_PAD,
        SEQ_PAD_WAIT,
        SEQ_OUT
    } t_seq_state;

    typedef struct packed {
        logic        push;
        logic        start;
        logic        shift_out;
        logic        init;
        logic [31:0] word;
    } t_core_cmd;

    typedef struct packed {
        logic        busy;
        logic [31:0] head_word;
    } t_core_stat;

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
        endcase
        return k;
    endfunction

endpackage

### hw/rtl/sha_if.sv
// valid/ready channel interfaces for message words and digest words
// no dependencies
interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;

    modport source (output valid, data_word, byte_count, last_word, input ready);
    modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    modport source (output valid, digest_word, word_index, digest_last, input ready);
    modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

### hw/rtl/sha_core.sv
// sha-256 compression engine: schedule window, working variables, chaining values
// depends on sha_pkg
module sha_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_core_cmd  i_cmd,
    output sha_pkg::t_core_stat o_stat
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    sha_pkg::t_core_state r_state, n_state;
    logic [5:0]  r_round, n_round;
    logic [31:0] r_chain [0:7];
    logic [31:0] r_var   [0:7];
    logic [31:0] r_win   [0:15];

    logic [31:0] s0, s1, sched_w, sig0, sig1, ch, maj, t1, t2, n_a, n_e;

    // one round per cycle; window slides so taps stay fixed
    always_comb begin
        s0      = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        s1      = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
        sched_w = r_win[0] + s0 + r_win[9] + s1;
        sig1    = rotr(r_var[4], 6) ^ rotr(r_var[4], 11) ^ rotr(r_var[4], 25);
        ch      = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        t1      = r_var[7] + sig1 + ch + sha_pkg::round_const(r_round) + r_win[0];
        sig0    = rotr(r_var[0], 2) ^ rotr(r_var[0], 13) ^ rotr(r_var[0], 22);
        maj     = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        t2      = sig0 + maj;
        n_a     = t1 + t2;
        n_e     = r_var[3] + t1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha_pkg::CORE_IDLE: begin
                if (i_cmd.start) begin
                    n_state = sha_pkg::CORE_ROUND;
                end
            end
            sha_pkg::CORE_ROUND: begin
                if (r_round == sha_pkg::LAST_ROUND) begin
                    n_state = sha_pkg::CORE_FFWD;
                end
            end
            sha_pkg::CORE_FFWD: n_state = sha_pkg::CORE_IDLE;
            default:            n_state = sha_pkg::CORE_IDLE;
        endcase
    end

    always_comb begin
        n_round          = '0;
        o_stat.busy      = 1'b1;
        o_stat.head_word = r_chain[0];
        unique case (r_state)
            sha_pkg::CORE_IDLE:  o_stat.busy = 1'b0;
            sha_pkg::CORE_ROUND: n_round = r_round + 6'd1;
            sha_pkg::CORE_FFWD:  n_round = '0;
            default:             o_stat.busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::CORE_IDLE;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= sha_pkg::SHA_IV[i];
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            if (r_state == sha_pkg::CORE_FFWD) begin
                for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_var[i];
            end else if (i_cmd.init) begin
                for (int i = 0; i < 8; i++) r_chain[i] <= sha_pkg::SHA_IV[i];
            end else if (i_cmd.shift_out) begin
                for (int i = 0; i < 7; i++) r_chain[i] <= r_chain[i + 1];
                r_chain[7] <= r_chain[0];
            end
        end
    end

    // schedule window and working variables carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i + 1];
            r_win[15] <= i_cmd.word;
        end else if (r_state == sha_pkg::CORE_ROUND) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i + 1];
            r_win[15] <= sched_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 8; i++) r_var[i] <= r_chain[i];
        end else if (r_state == sha_pkg::CORE_ROUND) begin
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= n_e;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= n_a;
        end
    end

endmodule

### hw/rtl/sha256_digest.sv
// sha-256 digest top level: message sequencer, padding, length and digest output
// depends on sha_pkg, sha_if and sha_core
//
// Message words arrive on i_msg as big-endian 32-bit beats; last_word marks the
// final beat and byte_count (0 to 4, larger values count as 4) gives its valid
// bytes from the top, the rest being ignored. Eight digest beats follow on
// o_digest, most significant word first, word_index 0..7, digest_last on the
// eighth; the engine then goes back to the initial hash values. Timing: words
// are taken one per cycle while a 64-byte block fills; the sixteenth word
// starts the shared round unit, which runs 64 rounds at one per cycle and then
// a feed-forward step, with i_msg.ready low until it is done. After the last
// word the sequencer pushes one padding or length word per cycle, pausing
// while a block compresses; one or two more compressions run, and the digest
// beats follow at one per cycle as the sink takes them. The message bit count
// wraps modulo 2^64.
module sha256_digest (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sha_in_if.sink   i_msg,
    sha_out_if.source o_digest
);

    localparam logic [2:0] FULL_BYTES   = 3'd4;
    localparam logic [3:0] LEN_HI_SLOT  = 4'd14;
    localparam logic [3:0] BLOCK_END    = 4'd15;
    localparam logic [2:0] LAST_INDEX   = 3'd7;

    // pad the final partial word: keep valid bytes, put the marker byte after them and zero the rest
    function automatic logic [31:0] pad_last(input logic [31:0] d, input logic [2:0] cnt);
        logic [31:0] w;
        case (cnt)
            3'd0:    w = sha_pkg::PAD_MARK;
            3'd1:    w = {d[31:24], 24'h80_0000};
            3'd2:    w = {d[31:16], 16'h8000};
            3'd3:    w = {d[31:8], 8'h80};
            default: w = d;
        endcase
        return w;
    endfunction

    sha_pkg::t_seq_state r_state, n_state;
    logic [3:0]  r_count, n_count;     // words held in the current block
    logic [63:0] r_len, n_len;         // message length in bits
    logic        r_mark, n_mark;       // marker word still owed after a full last word
    logic        r_hi_sent, n_hi_sent; // upper length word already pushed
    logic        r_final, n_final;     // last block of the message is compressing
    logic [2:0]  r_idx, n_idx;         // digest word being shown

    sha_pkg::t_core_cmd  core_cmd;
    sha_pkg::t_core_stat core_stat;

    logic        in_beat, out_beat;
    logic [2:0]  bc_sat;
    logic [31:0] pad_word;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (core_cmd),
        .o_stat  (core_stat)
    );

    // handshakes: input only in idle, output only while showing the digest
    assign i_msg.ready          = (r_state == sha_pkg::SEQ_IDLE);
    assign o_digest.valid       = (r_state == sha_pkg::SEQ_OUT);
    assign o_digest.digest_word = core_stat.head_word;
    assign o_digest.word_index  = r_idx;
    assign o_digest.digest_last = (r_idx == LAST_INDEX);

    assign in_beat  = i_msg.valid & i_msg.ready;
    assign out_beat = o_digest.valid & o_digest.ready;
    assign bc_sat   = (i_msg.byte_count > FULL_BYTES) ? FULL_BYTES : i_msg.byte_count;

    // padding stream: marker, zeros up to slot 14, then length high and low
    always_comb begin
        if (r_mark) begin
            pad_word = sha_pkg::PAD_MARK;
        end else if (r_hi_sent) begin
            pad_word = r_len[31:0];
        end else if (r_count == LEN_HI_SLOT) begin
            pad_word = r_len[63:32];
        end else begin
            pad_word = '0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha_pkg::SEQ_IDLE: begin
                if (in_beat) begin
                    if (r_count == BLOCK_END) begin
                        n_state = i_msg.last_word ? sha_pkg::SEQ_PAD_WAIT : sha_pkg::SEQ_BLOCK;
                    end else if (i_msg.last_word) begin
                        n_state = sha_pkg::SEQ_PAD;
                    end
                end
            end
            sha_pkg::SEQ_BLOCK: begin
                if (!core_stat.busy) begin
                    n_state = sha_pkg::SEQ_IDLE;
                end
            end
            sha_pkg::SEQ_PAD: begin
                if (r_count == BLOCK_END) begin
                    n_state = sha_pkg::SEQ_PAD_WAIT;
                end
            end
            sha_pkg::SEQ_PAD_WAIT: begin
                if (!core_stat.busy) begin
                    n_state = r_final ? sha_pkg::SEQ_OUT : sha_pkg::SEQ_PAD;
                end
            end
            sha_pkg::SEQ_OUT: begin
                if (out_beat && (r_idx == LAST_INDEX)) begin
                    n_state = sha_pkg::SEQ_IDLE;
                end
            end
            default: n_state = sha_pkg::SEQ_IDLE;
        endcase
    end

    // core commands and sequencer registers
    always_comb begin
        core_cmd  = '0;
        n_count   = r_count;
        n_len     = r_len;
        n_mark    = r_mark;
        n_hi_sent = r_hi_sent;
        n_final   = r_final;
        n_idx     = r_idx;
        unique case (r_state)
            sha_pkg::SEQ_IDLE: begin
                if (in_beat) begin
                    core_cmd.push  = 1'b1;
                    core_cmd.start = (r_count == BLOCK_END);
                    n_count        = r_count + 4'd1;
                    if (!i_msg.last_word) begin
                        core_cmd.word = i_msg.data_word;
                        n_len         = r_len + 64'd32;
                    end else begin
                        n_len     = r_len + {58'd0, bc_sat, 3'd0};
                        n_mark    = (bc_sat == FULL_BYTES);
                        n_hi_sent = 1'b0;
                        n_final   = 1'b0;
                        // a full last word goes in as is, the marker follows
                        core_cmd.word = (bc_sat == FULL_BYTES) ? i_msg.data_word
                                                               : pad_last(i_msg.data_word, bc_sat);
                    end
                end
            end
            sha_pkg::SEQ_PAD: begin
                core_cmd.push  = 1'b1;
                core_cmd.start = (r_count == BLOCK_END);
                core_cmd.word  = pad_word;
                n_count        = r_count + 4'd1;
                if (r_mark) begin
                    n_mark = 1'b0;
                end else if (r_hi_sent) begin
                    n_hi_sent = 1'b0;
                    n_final   = 1'b1;
                end else if (r_count == LEN_HI_SLOT) begin
                    n_hi_sent = 1'b1;
                end
            end
            sha_pkg::SEQ_OUT: begin
                if (out_beat) begin
                    core_cmd.shift_out = 1'b1;
                    n_idx              = r_idx + 3'd1;
                    if (r_idx == LAST_INDEX) begin
                        core_cmd.init = 1'b1;
                        n_len         = '0;
                        n_final       = 1'b0;
                    end
                end
            end
            default: begin
                core_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sha_pkg::SEQ_IDLE;
            r_count   <= '0;
            r_len     <= '0;
            r_mark    <= 1'b0;
            r_hi_sent <= 1'b0;
            r_final   <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_len     <= n_len;
            r_mark    <= n_mark;
            r_hi_sent <= n_hi_sent;
            r_final   <= n_final;
            r_idx     <= n_idx;
        end
    end

endmodule

### hw/rtl/sha_checker.sv
// port-level checks for sha256_digest, attached by bind
// depends on assert_macros.svh and sha256_digest
`include "assert_macros.svh"

module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_digest_word,
    input logic [2:0]  i_word_index,
    input logic        i_digest_last
);

    // no message beat is taken while the digest is shown
    `CHK_NEVER(a_no_overlap, i_clk, i_rst_n, i_in_ready && i_out_valid)

    // the last message word closes the input until the digest is out
    `CHK_ASSERT(a_last_closes, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)

    // digest words come in order, one index per beat
    `CHK_ASSERT(a_index_steps, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_digest_last |=> i_out_valid && (i_word_index == $past(i_word_index) + 3'd1))

    // the eighth beat ends the digest
    `CHK_ASSERT(a_last_ends, i_clk, i_rst_n, i_out_valid && i_out_ready && i_digest_last |=> !i_out_valid)

    // a stalled digest beat holds its word
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_digest_word))

endmodule

bind sha256_digest sha_checker u_sha_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_msg.valid),
    .i_in_ready    (i_msg.ready),
    .i_in_last     (i_msg.last_word),
    .i_out_valid   (o_digest.valid),
    .i_out_ready   (o_digest.ready),
    .i_digest_word (o_digest.digest_word),
    .i_word_index  (o_digest.word_index),
    .i_digest_last (o_digest.digest_last)
);

### tb/tb_top.sv
// self-checking testbench for sha256_digest: message words in, digest words out
// depends on sha_if (sha_in_if, sha_out_if) and the sha256_digest rtl
`timescale 1ns / 1ps

module tb_top;

    // least number of message beats that the random part adds after the directed part
    localparam int RANDOM_BEATS = 150;
    // beats left in the queue below which no new idling starts
    localparam int TAIL_BEATS   = 30;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [31:0] PAD_BYTE = 32'h0000_0080;

    // one message beat waiting to be sent
    typedef struct {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
        bit          drain;   // hold this beat until all digests are out
        bit          gappy;   // sender may idle after this beat
    } t_msg_beat;

    // one digest beat the engine owes us
    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } t_digest_beat;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  msg_if ();
    sha_out_if dig_if ();

    sha256_digest u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (msg_if),
        .o_digest (dig_if)
    );

    t_msg_beat    pending [$];
    t_digest_beat digest_q [$];
    t_msg_beat    nxt;
    t_digest_beat want;

    // predictor state: chaining values, word window, fill level, bit count
    logic [31:0] hv [8];
    logic [31:0] wnd [16];
    logic [3:0]  fill;
    logic [63:0] msg_bits;

    int  errors;
    int  words_sent;
    int  total_words;
    int  msgs_done;
    int  beats_seen;
    int  gap_left;
    int  stall_left;
    bit  stall_on;
    bit  quiet_tail;

    // ------------------------------------------------------------------
    // digest predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_chain();
        for (int i = 0; i < 8; i++)
            hv[i] = H_INIT[i];
        fill     = '0;
        msg_bits = '0;
    endfunction

    // 64 rounds over the full window, schedule expanded in place
    function automatic void run_rounds();
        logic [31:0] v [8];
        logic [31:0] x15, x2, s0, s1, w, e, a, t1, t2;
        for (int i = 0; i < 8; i++)
            v[i] = hv[i];
        for (int r = 0; r < 64; r++) begin
            if (r >= 16) begin
                x15 = wnd[(r - 15) & 15];
                x2  = wnd[(r - 2) & 15];
                s0  = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
                s1  = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
                wnd[r & 15] = wnd[r & 15] + s0 + wnd[(r - 7) & 15] + s1;
            end
            w  = wnd[r & 15];
            e  = v[4];
            a  = v[0];
            t1 = v[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
                 + ((e & v[5]) ^ (~e & v[6])) + ROUND_K[r] + w;
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
                 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hv[i] = hv[i] + v[i];
    endfunction

    // fill level is 4 bits, so wrapping to zero means the block is full
    function automatic void absorb_word(input logic [31:0] w);
        wnd[fill] = w;
        fill      = fill + 4'd1;
        if (fill == 4'd0)
            run_rounds();
    endfunction

    // one accepted message beat; a last beat pads, appends the length and
    // queues the eight digest words
    function automatic void predict_beat(input logic [31:0] d, input logic [2:0] c,
                                         input logic l);
        int          nb;
        logic [31:0] keep;
        t_digest_beat db;
        if (!l) begin
            msg_bits = msg_bits + 64'd32;
            absorb_word(d);
            return;
        end
        nb       = (c > 3'd4) ? 4 : int'(c);
        msg_bits = msg_bits + 64'(8 * nb);
        if (nb == 4) begin
            // full last word, the pad byte opens the next word
            absorb_word(d);
            absorb_word(PAD_WORD);
        end else begin
            // drop bytes past the count, pad byte right after the data
            keep = (nb == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - 8 * nb));
            absorb_word((d & keep) | (PAD_BYTE << (24 - 8 * nb)));
        end
        while (fill != 4'd14)
            absorb_word(32'd0);
        absorb_word(msg_bits[63:32]);
        absorb_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++) begin
            db.word = hv[i];
            db.idx  = 3'(i);
            db.fin  = (i == 7);
            digest_q.push_back(db);
        end
        clear_chain();
        msgs_done++;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_beat(input logic [31:0] d, input logic [2:0] c, input logic l,
                              input bit dr, input bit gp);
        t_msg_beat b;
        b.data  = d;
        b.cnt   = c;
        b.last  = l;
        b.drain = dr;
        b.gappy = gp;
        pending.push_back(b);
    endtask

    // message of random words; counts on the non-last words are noise
    task automatic queue_message(input int n_words, input logic [2:0] last_cnt,
                                 input bit dr, input bit gp);
        logic [31:0] d;
        for (int i = 0; i < n_words; i++) begin
            case ($urandom_range(0, 9))
                0:       d = 32'h0000_0000;
                1:       d = 32'hFFFF_FFFF;
                default: d = $urandom;
            endcase
            if (i == n_words - 1)
                queue_beat(d, last_cnt, 1'b1, dr && (n_words == 1), gp);
            else
                queue_beat(d, 3'($urandom_range(0, 7)), 1'b0, dr && (i == 0), gp);
        end
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // message driver: predicts on every accepted beat, then picks the next
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (msg_if.valid && msg_if.ready) begin
                predict_beat(msg_if.data_word, msg_if.byte_count, msg_if.last_word);
                words_sent++;
            end
            quiet_tail = (pending.size() < TAIL_BEATS);
            // channel free: either nothing shown or the shown beat just went
            if (!msg_if.valid || msg_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    msg_if.valid <= 1'b0;
                end else if (pending.size() == 0
                             || (pending[0].drain && digest_q.size() != 0)) begin
                    // out of beats, or holding off until every digest is back
                    msg_if.valid <= 1'b0;
                end else begin
                    nxt = pending.pop_front();
                    msg_if.valid      <= 1'b1;
                    msg_if.data_word  <= nxt.data;
                    msg_if.byte_count <= nxt.cnt;
                    msg_if.last_word  <= nxt.last;
                    // idle burst after this beat is taken
                    if (nxt.gappy && !quiet_tail && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 7);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // digest monitor: compares each beat and stalls the sink in bursts
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (dig_if.valid && dig_if.ready) begin
                beats_seen++;
                if (digest_q.size() == 0) begin
                    $error("digest beat %h index %0d with nothing expected",
                           dig_if.digest_word, dig_if.word_index);
                    errors++;
                end else begin
                    want = digest_q.pop_front();
                    if (dig_if.digest_word !== want.word) begin
                        $error("digest_word: expected %h, got %h",
                               want.word, dig_if.digest_word);
                        errors++;
                    end
                    if (dig_if.word_index !== want.idx) begin
                        $error("word_index: expected %0d, got %0d",
                               want.idx, dig_if.word_index);
                        errors++;
                    end
                    if (dig_if.digest_last !== want.fin) begin
                        $error("digest_last: expected %b, got %b",
                               want.fin, dig_if.digest_last);
                        errors++;
                    end
                end
                // new stall mood for the next digest
                if (dig_if.digest_last === 1'b1)
                    stall_on = ($urandom_range(0, 2) != 0);
            end
            if (stall_left > 0) begin
                stall_left--;
                dig_if.ready <= 1'b0;
            end else if (stall_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
                // start a stall burst
                stall_left = $urandom_range(0, 6);
                dig_if.ready <= 1'b0;
            end else begin
                dig_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------

    initial begin
        int sel;
        int n;
        // known values on every input before the first edge
        i_rst_n              = 1'b0;
        msg_if.valid         = 1'b0;
        msg_if.data_word     = 32'd0;
        msg_if.byte_count    = 3'd0;
        msg_if.last_word     = 1'b0;
        dig_if.ready         = 1'b0;
        errors      = 0;
        words_sent  = 0;
        msgs_done   = 0;
        beats_seen  = 0;
        gap_left    = 0;
        stall_left  = 0;
        stall_on    = 1'b0;
        quiet_tail  = 1'b0;
        clear_chain();

        // directed: empty message, junk in the word must be dropped
        queue_beat(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0, 1'b0);
        // "abc", sent only once the first digest is fully out
        queue_beat(32'h6162_6300, 3'd3, 1'b1, 1'b1, 1'b0);
        // single full word of ones, pad goes into its own word
        queue_beat(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0, 1'b1);
        // count above four saturates
        queue_beat(32'h0000_0000, 3'd7, 1'b1, 1'b0, 1'b1);
        // count on a middle word is ignored; last count 5 saturates
        queue_beat(32'hA5A5_A5A5, 3'd6, 1'b0, 1'b0, 1'b1);
        queue_beat(32'h5A5A_5A5A, 3'd5, 1'b1, 1'b0, 1'b1);
        // one and two valid bytes with junk below
        queue_beat(32'h12FF_FFFF, 3'd1, 1'b1, 1'b0, 1'b0);
        queue_beat(32'h3456_FFFF, 3'd2, 1'b1, 1'b0, 1'b1);
        // full last word at position 13: length spills into an extra block
        queue_message(14, 3'd4, 1'b1, 1'b1);

        // random messages, mostly short, some multi-block
        n = pending.size() + RANDOM_BEATS;
        while (pending.size() < n) begin
            sel = $urandom_range(0, 9);
            queue_message((sel < 6) ? $urandom_range(1, 16) :
                          (sel < 9) ? $urandom_range(17, 40) : $urandom_range(41, 70),
                          3'($urandom_range(0, 7)),
                          ($urandom_range(0, 5) == 0),
                          ($urandom_range(0, 2) != 0));
        end
        total_words = pending.size();

        // synchronous reset held from the start, never again
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all beats sent, every digest back, then a quiet stretch
        while (words_sent != total_words || digest_q.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("summary: %0d message words in %0d messages, %0d digest beats compared",
                 words_sent, msgs_done, beats_seen);
        if (errors == 0 && digest_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #(2_000_000);
        $display("timeout: %0d of %0d words sent, %0d digest beats outstanding",
                 words_sent, total_words, digest_q.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
